// ===== rtl/ptrm_pkg.sv =====
`default_nettype none

package ptrm_pkg;

	localparam int unsigned TABLE_COUNT_DEFAULT = 8;

	// Each directory entry and each page table covers 1024 entries.
	localparam int unsigned ENTRY_BITS = 10;
	localparam int unsigned ENTRIES    = 1024;

	// Page frame number width and entry flag width.
	localparam int unsigned FRAME_W = 20;
	localparam int unsigned FLAGS_W = 12;

	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [FLAGS_W-1:0] FLAG_VALID     = 12'h001;
	localparam logic [FLAGS_W-1:0] FLAG_WRITE     = 12'h002;
	localparam logic [FLAGS_W-1:0] FLAG_USER      = 12'h004;
	localparam logic [FLAGS_W-1:0] FLAG_SUPERPAGE = 12'h080;
	localparam logic [FLAGS_W-1:0] TABLE_DIR_FLAGS = FLAG_VALID | FLAG_WRITE | FLAG_USER;

	localparam int unsigned VALID_BIT = 0;
	localparam int unsigned SUPER_BIT = 7;

	typedef enum logic [0:0] {
		OP_MAP  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_MAPPED       = 2'd1,
		ST_SUPER_BLOCKS = 2'd2,
		ST_NO_TABLE     = 2'd3
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SUPERPAGE_ENABLE = 2'd0,
		REG_TABLE_POOL_BASE  = 2'd1
	} reg_index_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIR_RD,
		S_DIR_CHK,
		S_TAB_CLR,
		S_TAB_RD,
		S_TAB_RUN,
		S_FIN_RD,
		S_FIN_DE,
		S_FIN_TE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/page_table_range_mapper_unit.sv =====
`default_nettype none
// A read passes S_FIN_RD, S_FIN_DE, and S_FIN_TE when a table entry is fetched; done is
// registered from the last. A map run passes S_DIR_RD and S_DIR_CHK per 4MB entry, S_TAB_RD
// and one S_TAB_RUN per 4KB entry per table step, S_DIR_RD once more when the count runs out,
// and an S_TAB_CLR sweep of all 1024 entries per untouched table. One transaction at a time;
// start is taken only while busy is low. Reset: a sweep of all 1024 directory entries follows
// reset, with busy high; results are strobed on done for one cycle and the receiver cannot stall them.
module page_table_range_mapper_unit #(
	parameter int unsigned TABLE_COUNT = ptrm_pkg::TABLE_COUNT_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic                                 operation,
	input  wire logic [31:0]                          virt_addr,
	input  wire logic [31:0]                          phys_addr,
	input  wire logic [20:0]                          page_count,
	input  wire logic [ptrm_pkg::FLAGS_W-1:0]         entry_flags,
	output logic                                      done,
	output logic [1:0]                                status,
	output logic [31:0]                               directory_entry,
	output logic [31:0]                               table_entry,
	output logic [20:0]                               pages_mapped,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [ptrm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [31:0]                          cfg_data
);
	import ptrm_pkg::*;

	localparam int unsigned SLOT_W     = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
	localparam int unsigned USED_W     = $clog2(TABLE_COUNT + 1);
	localparam int unsigned POOL_AW    = SLOT_W + ENTRY_BITS;
	localparam int unsigned POOL_DEPTH = TABLE_COUNT * ENTRIES;

	// Memories.
	logic [31:0] dir_q  [ENTRIES];
	logic [31:0] pool_q [POOL_DEPTH];
	logic [31:0] dir_rdata_q;
	logic [31:0] pool_rdata_q;

	logic                  dir_we, dir_re;
	logic [ENTRY_BITS-1:0] dir_waddr, dir_raddr;
	logic [31:0]           dir_wdata;
	logic                  pool_we, pool_re;
	logic [POOL_AW-1:0]    pool_waddr, pool_raddr;
	logic [31:0]           pool_wdata;

	// Control state.
	state_t                 state_q, state_d;
	logic [ENTRY_BITS-1:0]  clr_q, clr_d;
	logic [USED_W-1:0]      used_q;
	logic                   used_inc;
	logic [TABLE_COUNT-1:0] touched_q;
	logic                   touched_set;
	logic                   done_q, done_d;
	logic                   sp_en_q;
	logic [FRAME_W-1:0]     base_q;

	// Run context.
	op_t                op_q, op_d;
	logic [FRAME_W-1:0] va_q, va_d, va0_q, va0_d, pa_q, pa_d;
	logic [20:0]        left_q, left_d, count_q, count_d;
	logic [FLAGS_W-1:0] flags_q, flags_d;
	status_t            status_q, status_d;
	logic [SLOT_W-1:0]  slot_q, slot_d;

	// Result registers.
	status_t     res_status_q, res_status_d;
	logic [31:0] res_dir_q, res_dir_d, res_tab_q, res_tab_d;
	logic [20:0] res_pages_q, res_pages_d;

	// Decode of the directory entry just read.
	logic [FRAME_W-1:0] de_off;
	logic               de_valid, de_super, de_in_range, super_ok, used_full;
	logic [SLOT_W-1:0]  de_slot, new_slot;
	logic [FRAME_W-1:0] new_frame, va_n;

	assign de_off      = dir_rdata_q[31:12] - base_q;
	assign de_in_range = de_off < FRAME_W'(TABLE_COUNT);
	assign de_slot     = de_off[SLOT_W-1:0];
	assign de_valid    = dir_rdata_q[VALID_BIT];
	assign de_super    = dir_rdata_q[SUPER_BIT];
	assign new_slot    = used_q[SLOT_W-1:0];
	assign new_frame   = base_q + FRAME_W'(used_q);
	assign used_full   = used_q >= USED_W'(TABLE_COUNT);
	assign va_n        = va_q + FRAME_W'(1);
	assign super_ok    = (va_q[ENTRY_BITS-1:0] == '0) && (pa_q[ENTRY_BITS-1:0] == '0) &&
		(left_q >= 21'(ENTRIES)) && sp_en_q;

	always_comb begin
		state_d      = state_q;
		clr_d        = clr_q;
		used_inc     = 1'b0;
		touched_set  = 1'b0;
		done_d       = 1'b0;
		op_d         = op_q;
		va_d         = va_q;
		va0_d        = va0_q;
		pa_d         = pa_q;
		left_d       = left_q;
		count_d      = count_q;
		flags_d      = flags_q;
		status_d     = status_q;
		slot_d       = slot_q;
		res_status_d = res_status_q;
		res_dir_d    = res_dir_q;
		res_tab_d    = res_tab_q;
		res_pages_d  = res_pages_q;
		dir_we       = 1'b0;
		dir_re       = 1'b0;
		dir_waddr    = va_q[FRAME_W-1:ENTRY_BITS];
		dir_raddr    = va_q[FRAME_W-1:ENTRY_BITS];
		dir_wdata    = '0;
		pool_we      = 1'b0;
		pool_re      = 1'b0;
		pool_waddr   = {slot_q, va_q[ENTRY_BITS-1:0]};
		pool_raddr   = {slot_q, va_q[ENTRY_BITS-1:0]};
		pool_wdata   = '0;

		unique case (state_q)
			S_CLEAR: begin
				dir_we    = 1'b1;
				dir_waddr = clr_q;
				clr_d     = clr_q + ENTRY_BITS'(1);
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					op_d     = op_t'(operation);
					va_d     = virt_addr[31:12];
					va0_d    = virt_addr[31:12];
					pa_d     = phys_addr[31:12];
					left_d   = page_count;
					flags_d  = entry_flags;
					count_d  = '0;
					status_d = ST_OK;
					state_d  = (op_t'(operation) == OP_READ) ? S_FIN_RD : S_DIR_RD;
				end
			end
			S_DIR_RD: begin
				if (left_q == '0) begin
					state_d = S_FIN_RD;
				end else begin
					dir_re  = 1'b1;
					state_d = S_DIR_CHK;
				end
			end
			S_DIR_CHK: begin
				priority if (super_ok) begin
					if (de_valid) begin
						status_d = ST_MAPPED;
						state_d  = S_FIN_RD;
					end else begin
						dir_we    = 1'b1;
						dir_wdata = {pa_q, flags_q | FLAG_SUPERPAGE};
						va_d      = va_q + FRAME_W'(ENTRIES);
						pa_d      = pa_q + FRAME_W'(ENTRIES);
						left_d    = left_q - 21'(ENTRIES);
						count_d   = count_q + 21'(ENTRIES);
						state_d   = S_DIR_RD;
					end
				end else if (!de_valid) begin
					if (used_full) begin
						status_d = ST_NO_TABLE;
						state_d  = S_FIN_RD;
					end else begin
						// A new table always lands at the slot given by the fill count.
						dir_we    = 1'b1;
						dir_wdata = {new_frame, TABLE_DIR_FLAGS};
						used_inc  = 1'b1;
						slot_d    = new_slot;
						state_d   = touched_q[new_slot] ? S_TAB_RD : S_TAB_CLR;
					end
				end else if (de_super) begin
					status_d = ST_SUPER_BLOCKS;
					state_d  = S_FIN_RD;
				end else if (!de_in_range) begin
					status_d = ST_NO_TABLE;
					state_d  = S_FIN_RD;
				end else begin
					slot_d  = de_slot;
					state_d = touched_q[de_slot] ? S_TAB_RD : S_TAB_CLR;
				end
			end
			S_TAB_CLR: begin
				// A pool table is zeroed the first time a map run reaches it.
				pool_we    = 1'b1;
				pool_waddr = {slot_q, clr_q};
				clr_d      = clr_q + ENTRY_BITS'(1);
				if (clr_q == '1) begin
					touched_set = 1'b1;
					state_d     = S_TAB_RD;
				end
			end
			S_TAB_RD: begin
				pool_re = 1'b1;
				state_d = S_TAB_RUN;
			end
			S_TAB_RUN: begin
				if (pool_rdata_q[VALID_BIT]) begin
					status_d = ST_MAPPED;
					state_d  = S_FIN_RD;
				end else begin
					// Write this entry and fetch the next one in the same cycle.
					pool_we    = 1'b1;
					pool_wdata = {pa_q, flags_q};
					va_d       = va_n;
					pa_d       = pa_q + FRAME_W'(1);
					left_d     = left_q - 21'(1);
					count_d    = count_q + 21'(1);
					if ((left_q != 21'(1)) && (va_n[ENTRY_BITS-1:0] != '0)) begin
						pool_re    = 1'b1;
						pool_raddr = {slot_q, va_n[ENTRY_BITS-1:0]};
					end else begin
						state_d = S_DIR_RD;
					end
				end
			end
			S_FIN_RD: begin
				dir_re    = 1'b1;
				dir_raddr = va0_q[FRAME_W-1:ENTRY_BITS];
				state_d   = S_FIN_DE;
			end
			S_FIN_DE: begin
				res_dir_d    = dir_rdata_q;
				res_status_d = status_q;
				res_pages_d  = count_q;
				if (de_valid && !de_super && de_in_range && touched_q[de_slot]) begin
					pool_re    = 1'b1;
					pool_raddr = {de_slot, va0_q[ENTRY_BITS-1:0]};
					state_d    = S_FIN_TE;
				end else begin
					res_tab_d = '0;
					done_d    = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_FIN_TE: begin
				res_tab_d = pool_rdata_q;
				done_d    = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			used_q    <= '0;
			touched_q <= '0;
			done_q    <= 1'b0;
			sp_en_q   <= 1'b0;
			base_q    <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			done_q  <= done_d;
			if (used_inc) begin
				used_q <= used_q + USED_W'(1);
			end
			if (touched_set) begin
				touched_q[slot_q] <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (reg_index_t'(cfg_index))
					REG_SUPERPAGE_ENABLE: sp_en_q <= cfg_data[0];
					REG_TABLE_POOL_BASE:  base_q  <= cfg_data[31:12];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q         <= op_d;
		va_q         <= va_d;
		va0_q        <= va0_d;
		pa_q         <= pa_d;
		left_q       <= left_d;
		count_q      <= count_d;
		flags_q      <= flags_d;
		status_q     <= status_d;
		slot_q       <= slot_d;
		res_status_q <= res_status_d;
		res_dir_q    <= res_dir_d;
		res_tab_q    <= res_tab_d;
		res_pages_q  <= res_pages_d;
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_q[dir_waddr] <= dir_wdata;
		end
		if (dir_re) begin
			dir_rdata_q <= dir_q[dir_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pool_we) begin
			pool_q[pool_waddr] <= pool_wdata;
		end
		if (pool_re) begin
			pool_rdata_q <= pool_q[pool_raddr];
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign cfg_ready       = 1'b1;
	assign done            = done_q;
	assign status          = res_status_q;
	assign directory_entry = res_dir_q;
	assign table_entry     = res_tab_q;
	assign pages_mapped    = res_pages_q;

`ifndef SYNTH
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe lasted more than one cycle");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_COUNT))
		else $error("table fill count beyond pool size");

	a_pool_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(pool_we && pool_re) |-> (pool_waddr != pool_raddr))
		else $error("pool read and write hit the same entry");

	a_table_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAB_RD) |-> touched_q[slot_q])
		else $error("table entries read before the table was cleared");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (op_q == OP_READ)) |-> ((res_pages_q == '0) && (res_status_q == ST_OK)))
		else $error("read transaction reported a mapping result");
`endif

endmodule

`default_nettype wire
